// ===== rtl/dvru_pkg.sv =====
// ----------------------------------------------------------------------------
// Route update package
// Shared types and constants for the distance-vector route update block.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned TableDepthDef    = 16;
  localparam int unsigned AddrWidthDef     = 32;
  localparam int unsigned MaxInterfacesDef = 4;

  // Fixed field widths.
  localparam int unsigned CostW     = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned IfCountW  = 3;

  // Route costs.
  localparam logic [CostW-1:0] InfCost  = 5'd16;
  localparam logic [CostW-1:0] LinkCost = 5'd1;
  localparam logic [CostW-1:0] NullCost = 5'd0;

  // Configuration register indices.
  localparam logic [CfgIdxW-1:0] CfgIfaceCount = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgForced     = 3'd5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_UPDATED   = 2'd1,
    ST_UNCHANGED = 2'd2,
    ST_FULL      = 2'd3
  } dvru_status_e;

  // Write command broadcast to every table cell.
  typedef struct packed {
    logic ins;  // new entry: destination, next hop, interface and cost
    logic upd;  // existing entry: next hop and cost only
  } dvru_wr_t;

endpackage

`default_nettype wire

// ===== rtl/dvru_cell.sv =====
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route entry, compares it with the query and merges its entry into
// the search chain passed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_cell
  import dvru_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = AddrWidthDef,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned CELL_IDX   = 0
) (
  input  wire logic                  clk_i,
  input  wire logic [ADDR_WIDTH-1:0] query_dest_i,
  input  wire logic [CNT_W-1:0]      fill_cnt_i,
  input  wire dvru_wr_t              wr_i,
  input  wire logic [IDX_W-1:0]      wr_idx_i,
  input  wire logic [ADDR_WIDTH-1:0] wr_dest_i,
  input  wire logic [ADDR_WIDTH-1:0] wr_nh_i,
  input  wire logic [ADDR_WIDTH-1:0] wr_ifc_i,
  input  wire logic [CostW-1:0]      wr_cost_i,
  input  wire logic                  hit_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire logic [CostW-1:0]      cost_i,
  input  wire logic [ADDR_WIDTH-1:0] nh_i,
  input  wire logic [ADDR_WIDTH-1:0] ifc_i,
  output logic                       hit_o,
  output logic [IDX_W-1:0]           idx_o,
  output logic [CostW-1:0]           cost_o,
  output logic [ADDR_WIDTH-1:0]      nh_o,
  output logic [ADDR_WIDTH-1:0]      ifc_o
);

  logic [ADDR_WIDTH-1:0] dest_q;
  logic [ADDR_WIDTH-1:0] nh_q;
  logic [ADDR_WIDTH-1:0] ifc_q;
  logic [CostW-1:0]      cost_q;
  logic                  live;
  logic                  match;
  logic                  sel;

  // The entry is only meaningful once the fill count has passed this slot.
  assign live  = fill_cnt_i > CNT_W'(CELL_IDX);
  assign match = live && (dest_q == query_dest_i);
  assign sel   = wr_idx_i == IDX_W'(CELL_IDX);

  // Entry storage, written by the broadcast command when this slot is chosen.
  always_ff @(posedge clk_i) begin
    if (wr_i.ins && sel) begin
      dest_q <= wr_dest_i;
      ifc_q  <= wr_ifc_i;
    end
    if ((wr_i.ins || wr_i.upd) && sel) begin
      nh_q   <= wr_nh_i;
      cost_q <= wr_cost_i;
    end
  end

  // Search chain: a matching entry replaces what came from the left.
  always_comb begin
    hit_o  = hit_i || match;
    idx_o  = match ? IDX_W'(CELL_IDX) : idx_i;
    cost_o = match ? cost_q : cost_i;
    nh_o   = match ? nh_q : nh_i;
    ifc_o  = match ? ifc_q : ifc_i;
  end

endmodule

`default_nettype wire

// ===== rtl/distance_vector_route_update.sv =====
// Each accepted item is held in the query register while the chain of table
// cells is searched; the entry is written back and the result is registered
// when the item is resolved. No new item is taken until the held one is resolved.
// Results wait in an output register; a stalled result delays the next item.
// Reset clears the fill count, the configuration and the handshakes; table
// cells are not cleared, as only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
// Distance-vector route update
// Searches a chain of route cells for an advertised destination, then inserts,
// updates or keeps the entry and reports the route held afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update
  import dvru_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH    = TableDepthDef,
  parameter int unsigned ADDR_WIDTH     = AddrWidthDef,
  parameter int unsigned MAX_INTERFACES = MaxInterfacesDef,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  // Advertisement channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [ADDR_WIDTH-1:0] dest_addr_i,
  input  wire logic [CostW-1:0]      adv_cost_i,
  input  wire logic [ADDR_WIDTH-1:0] sender_addr_i,
  input  wire logic [ADDR_WIDTH-1:0] arrival_iface_addr_i,
  // Result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 status_o,
  output logic [IdxW-1:0]            entry_index_o,
  output logic [CostW-1:0]           route_cost_o,
  output logic [ADDR_WIDTH-1:0]      route_next_hop_o,
  output logic [ADDR_WIDTH-1:0]      route_interface_o
);

  // Configuration registers.
  logic [ADDR_WIDTH-1:0] iface_q [MAX_INTERFACES];
  logic [IfCountW-1:0]   iface_cnt_q;
  logic                  forced_q;
  logic [ADDR_WIDTH-1:0] cfg_addr;

  // Query and control.
  logic                  busy_q, busy_d;
  logic                  in_xfer;
  logic                  proc;
  logic [ADDR_WIDTH-1:0] q_dest_q, q_from_q, q_arr_q;
  logic [CostW-1:0]      q_adv_q;
  logic [CntW-1:0]       fill_q, fill_d;

  // Search chain between cells.
  logic                  ch_hit  [TABLE_DEPTH+1];
  logic [IdxW-1:0]       ch_idx  [TABLE_DEPTH+1];
  logic [CostW-1:0]      ch_cost [TABLE_DEPTH+1];
  logic [ADDR_WIDTH-1:0] ch_nh   [TABLE_DEPTH+1];
  logic [ADDR_WIDTH-1:0] ch_ifc  [TABLE_DEPTH+1];

  // Decision and write-back.
  logic                  is_local;
  logic                  hit;
  logic                  full;
  logic                  take;
  logic [CostW:0]        adv_inc;
  logic [CostW-1:0]      hop;
  logic [CostW-1:0]      ins_cost;
  dvru_wr_t              wr;
  logic [IdxW-1:0]       wr_idx;
  logic [CostW-1:0]      wr_cost;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  dvru_status_e          st_q, st_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CostW-1:0]      cost_q, cost_d;
  logic [ADDR_WIDTH-1:0] nh_q, nh_d;
  logic [ADDR_WIDTH-1:0] ifc_q, ifc_d;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_addr    = ADDR_WIDTH'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_INTERFACES; k++) begin
        iface_q[k] <= '0;
      end
      iface_cnt_q <= '0;
      forced_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      for (int k = 0; k < MAX_INTERFACES; k++) begin
        if (cfg_index_i == CfgIdxW'(k)) begin
          iface_q[k] <= cfg_addr;
        end
      end
      if (cfg_index_i == CfgIfaceCount) begin
        iface_cnt_q <= cfg_data_i[IfCountW-1:0];
      end
      if (cfg_index_i == CfgForced) begin
        forced_q <= cfg_data_i[0];
      end
    end
  end

  // Handshake: one item is held in the query register until it is resolved.
  assign in_stall_o = busy_q;
  assign in_xfer    = in_valid_i && !busy_q;
  assign proc       = busy_q && (!out_valid_q || !out_stall_i);
  assign busy_d     = in_xfer ? 1'b1 : (proc ? 1'b0 : busy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fill_q <= '0;
    end else begin
      busy_q <= busy_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      q_dest_q <= dest_addr_i;
      q_adv_q  <= adv_cost_i;
      q_from_q <= sender_addr_i;
      q_arr_q  <= arrival_iface_addr_i;
    end
  end

  // Row of table cells; the chain enters empty at the left end.
  assign ch_hit[0]  = 1'b0;
  assign ch_idx[0]  = '0;
  assign ch_cost[0] = '0;
  assign ch_nh[0]   = '0;
  assign ch_ifc[0]  = '0;

  for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
    dvru_cell #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .IDX_W      (IdxW),
      .CNT_W      (CntW),
      .CELL_IDX   (c)
    ) u_cell (
      .clk_i        (clk_i),
      .query_dest_i (q_dest_q),
      .fill_cnt_i   (fill_q),
      .wr_i         (wr),
      .wr_idx_i     (wr_idx),
      .wr_dest_i    (q_dest_q),
      .wr_nh_i      (q_from_q),
      .wr_ifc_i     (q_arr_q),
      .wr_cost_i    (wr_cost),
      .hit_i        (ch_hit[c]),
      .idx_i        (ch_idx[c]),
      .cost_i       (ch_cost[c]),
      .nh_i         (ch_nh[c]),
      .ifc_i        (ch_ifc[c]),
      .hit_o        (ch_hit[c+1]),
      .idx_o        (ch_idx[c+1]),
      .cost_o       (ch_cost[c+1]),
      .nh_o         (ch_nh[c+1]),
      .ifc_o        (ch_ifc[c+1])
    );
  end

  // Local interface check: only the first iface_count registers are active.
  always_comb begin
    is_local = 1'b0;
    for (int k = 0; k < MAX_INTERFACES; k++) begin
      if ((IfCountW'(k) < iface_cnt_q) && (iface_q[k] == q_dest_q)) begin
        is_local = 1'b1;
      end
    end
  end

  // Cost arithmetic: advertised cost plus one link, saturated at infinity.
  assign adv_inc  = {1'b0, q_adv_q} + {1'b0, LinkCost};
  assign hop      = (adv_inc > {1'b0, InfCost}) ? InfCost : adv_inc[CostW-1:0];
  assign ins_cost = (q_from_q == q_dest_q) ? LinkCost : hop;

  assign hit  = ch_hit[TABLE_DEPTH];
  assign full = fill_q == CntW'(TABLE_DEPTH);
  assign take = forced_q || ({1'b0, ch_cost[TABLE_DEPTH]} > adv_inc);

  // Decision, table write-back and the result to be registered.
  always_comb begin
    wr.ins  = 1'b0;
    wr.upd  = 1'b0;
    wr_idx  = fill_q[IdxW-1:0];
    wr_cost = ins_cost;
    fill_d  = fill_q;
    st_d    = ST_UNCHANGED;
    idx_d   = '0;
    cost_d  = NullCost;
    nh_d    = q_dest_q;
    ifc_d   = q_dest_q;
    if (is_local) begin
      // Permanent cost-zero route; defaults above already describe it.
    end else if (hit) begin
      wr_idx = ch_idx[TABLE_DEPTH];
      idx_d  = ch_idx[TABLE_DEPTH];
      ifc_d  = ch_ifc[TABLE_DEPTH];
      if (take) begin
        wr.upd  = proc;
        wr_cost = hop;
        st_d    = ST_UPDATED;
        cost_d  = hop;
        nh_d    = q_from_q;
      end else begin
        cost_d = ch_cost[TABLE_DEPTH];
        nh_d   = ch_nh[TABLE_DEPTH];
      end
    end else if (full) begin
      st_d   = ST_FULL;
      cost_d = InfCost;
      nh_d   = '0;
      ifc_d  = '0;
    end else begin
      wr.ins = proc;
      st_d   = ST_INSERTED;
      idx_d  = fill_q[IdxW-1:0];
      cost_d = ins_cost;
      nh_d   = q_from_q;
      ifc_d  = q_arr_q;
      if (proc) begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  // Output register: a result stays until it is transferred.
  assign out_valid_d = proc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      cost_q <= cost_d;
      nh_q   <= nh_d;
      ifc_q  <= ifc_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = st_q;
  assign entry_index_o     = idx_q;
  assign route_cost_o      = cost_q;
  assign route_next_hop_o  = nh_q;
  assign route_interface_o = ifc_q;

`ifndef SYNTHESIS
  // The fill count never runs past the table.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // The fill count moves only when an item is resolved.
  a_fill_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(fill_q))
    else $error("fill count changed without an item");

  // An accepted item occupies the query register in the next cycle.
  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q)
    else $error("query register not held after transfer");

  // A table-full result is only reported when every slot is in use.
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (st_q == ST_FULL)) |-> full)
    else $error("table full reported with free slots");
`endif

endmodule

`default_nettype wire
